### rtl/assert_macros.svh
// Assertion macros used by the converter checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/f2h_pkg.sv
// ----------------------------------------------------------------------------
// f2h_pkg: shared constants for the binary16/binary32 converter
// Operation codes.
// ----------------------------------------------------------------------------
`default_nettype none
package f2h_pkg;
    typedef enum logic
    {
        OP_H2S = 1'b0,
        OP_S2H = 1'b1
    } op_t;
endpackage
`default_nettype wire

### rtl/fp32_fp16_converter.sv
// ----------------------------------------------------------------------------
// fp32_fp16_converter: IEEE binary16 <-> binary32 conversion
// Direction chosen per request; one request per cycle.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// request   in         start, busy, op, value_in
// result    out        done, value_out
//
// A request is taken on any edge where start is high; busy is always low.
// The operands are registered, converted in one combinational pass, and the
// result is registered: done follows the request through the input valid
// register and then the output valid register, and the result is taken with done.
// The pipeline holds two requests at most and moves every cycle.
// Reset clears the valid flags only; the receiver cannot stall.
`default_nettype none
module fp32_fp16_converter
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        op,
    input  wire logic [31:0] value_in,
    output logic             done,
    output logic [31:0]      value_out
);
    logic        in_vld_reg;
    logic        op_reg;
    logic [31:0] val_reg;
    logic        out_vld_reg;
    logic [31:0] out_reg;
    logic [31:0] h2s_res;
    logic [15:0] s2h_res;
    logic [31:0] res_next;

    assign busy = 1'b0;

    f2h_h2s u_h2s (.half(val_reg[15:0]), .single(h2s_res));
    f2h_s2h u_s2h (.single(val_reg), .half(s2h_res));

    // Pick the direction that the request asked for.
    assign res_next = (f2h_pkg::op_t'(op_reg) == f2h_pkg::OP_H2S) ? h2s_res
                                                                  : {16'd0, s2h_res};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= start;
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg  <= op;
            val_reg <= value_in;
        end
        out_reg <= res_next;
    end

    assign done = out_vld_reg;
    assign value_out = out_reg;
endmodule
`default_nettype wire

### rtl/f2h_h2s.sv
// ----------------------------------------------------------------------------
// f2h_h2s: half to single widening
// Rebiases the exponent, normalizes subnormals, maps specials.
// ----------------------------------------------------------------------------
`default_nettype none
module f2h_h2s
(
    input  wire logic [15:0] half,
    output logic [31:0]      single
);
    logic       s;
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] p;
    logic [7:0] se;
    logic [22:0] sm;

    assign s = half[15];
    assign e = half[14:10];
    assign m = half[9:0];

    // Priority encoder for the leading one of a subnormal mantissa.
    always_comb
    begin
        p = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (m[i])
            begin
                p = 4'(i);
            end
        end
    end

    always_comb
    begin
        se = 8'd0;
        sm = 23'd0;
        single = 32'd0;
        if (e == 5'd0)
        begin
            if (m != 10'd0)
            begin
                se = 8'(p) + 8'd103;
                sm = 23'({13'd0, m} << (5'd23 - 5'(p)));
                single = {s, se, sm};
            end
        end
        else if (e == 5'h1f)
        begin
            single = {s, 8'hff, m, 13'd0};
        end
        else
        begin
            single = {s, 8'(e) + 8'd112, m, 13'd0};
        end
    end
endmodule
`default_nettype wire

### rtl/f2h_s2h.sv
// ----------------------------------------------------------------------------
// f2h_s2h: single to half narrowing
// Saturates, flushes tiny values, rounds to nearest with ties away.
// ----------------------------------------------------------------------------
`default_nettype none
module f2h_s2h
(
    input  wire logic [31:0] single,
    output logic [15:0]      half
);
    logic        s;
    logic [7:0]  e;
    logic [22:0] f;
    logic [23:0] sig;
    logic [4:0]  shift;
    logic [24:0] sub_sum;
    logic [10:0] sub_m;
    logic [10:0] nm;

    assign s = single[31];
    assign e = single[30:23];
    assign f = single[22:0];
    assign sig = {1'b1, f};
    assign shift = 5'(8'd126 - e);
    // Add half an ulp at the shifted position, then shift out.
    assign sub_sum = {1'b0, sig} + (25'd1 << (shift - 5'd1));
    assign sub_m = 11'(sub_sum >> shift);
    assign nm = 11'(({1'b0, f} + 24'h1000) >> 13);

    always_comb
    begin
        if (e == 8'hff && f != 23'd0)
        begin
            half = {s, 5'h1f, 10'd1};
        end
        else if (single[30:0] >= 31'h477fe000)
        begin
            half = {s, 15'h7bff};
        end
        else if (e < 8'd102)
        begin
            half = 16'd0;
        end
        else if (e <= 8'd112)
        begin
            half = {s, 15'(sub_m)};
        end
        else
        begin
            half = {s, 15'({5'(e - 8'd112), 10'd0} + 15'(nm))};
        end
    end
endmodule
`default_nettype wire

### rtl/f2h_checker.sv
// ----------------------------------------------------------------------------
// f2h_checker: port-level checks for the converter
// Latency and result format rules seen at the ports.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module f2h_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        op,
    input wire logic        done,
    input wire logic [31:0] value_out
);
    `ASSERT_IMPL(a_never_busy, clk, rst_n, 1'b1, !busy)
    `ASSERT_NEXT(a_latency, clk, rst_n, start && !busy, ##1 done)
    `ASSERT_NEXT(a_no_spurious, clk, rst_n, !start, ##1 !done)
    `ASSERT_NEXT(a_half_upper_zero, clk, rst_n, start && op, ##1 (value_out[31:16] == 16'd0))
endmodule
bind fp32_fp16_converter f2h_checker u_f2h_checker (.*);
`default_nettype wire

### tb/tb_fp32_fp16_converter.sv
// ----------------------------------------------------------------------------
// tb_fp32_fp16_converter: self-checking bench for the half/single converter
// Drives a directed table of conversions and then random requests, predicts
// each result in both directions and compares it with the done strobe output.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_fp32_fp16_converter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumRandom  = 1400;
    localparam int CycleLimit = 200000;
    localparam int TailCycles = 8;

    // One row of the directed table. When has_exp is set, the expected word is
    // typed in and also compared with the predictor as a sanity check.
    typedef struct {
        f2h_pkg::op_t op;
        logic [31:0]  value;
        bit           has_exp;
        logic [31:0]  exp_word;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    f2h_pkg::op_t op;
    logic [31:0]  value_in;
    logic         done;
    logic [31:0]  value_out;

    logic [31:0] pending_words[$];
    int          mismatches;
    int          cycles;

    fp32_fp16_converter uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .value_in  (value_in),
        .done      (done),
        .value_out (value_out)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Half to single: rebias, widen, and normalize subnormals exactly.
    function automatic logic [31:0] widen_half(logic [15:0] h);
        logic       sgn;
        logic [4:0] ex;
        logic [9:0] man;
        int         lead;
        logic [22:0] frac;
        sgn  = h[15];
        ex   = h[14:10];
        man  = h[9:0];
        lead = 0;
        if (ex == 5'd0)
        begin
            if (man == 10'd0)
                return 32'd0;
            for (int i = 0; i < 10; i++)
                if (man[i])
                    lead = i;
            frac = 23'({13'd0, man} << (23 - lead));
            return {sgn, 8'(lead + 103), frac};
        end
        if (ex == 5'h1f)
            return {sgn, 8'hff, man, 13'd0};
        return {sgn, 8'(ex + 112), man, 13'd0};
    endfunction

    // Single to half: clamp, flush tiny values, round half away from zero.
    function automatic logic [31:0] narrow_single(logic [31:0] u);
        logic        sgn;
        logic [7:0]  ex;
        logic [22:0] frac;
        logic [31:0] sig;
        logic [31:0] m;
        logic [15:0] half;
        int          sh;
        sgn  = u[31];
        ex   = u[30:23];
        frac = u[22:0];
        if (ex == 8'hff && frac != 23'd0)
            return {16'd0, sgn, 5'h1f, 10'd1};
        if (u[30:0] >= 31'h477fe000)
            return {16'd0, sgn, 15'h7bff};
        if (ex < 8'd102)
            return 32'd0;
        if (ex <= 8'd112)
        begin
            sig = {9'd0, 1'b1, frac};
            sh  = 126 - ex;
            m   = (sig + (32'd1 << (sh - 1))) >> sh;
            half = {sgn, 15'(m)};
            return {16'd0, half};
        end
        m    = ({9'd0, frac} + 32'h1000) >> 13;
        half = {sgn, 15'((32'(ex - 112) << 10) + m)};
        return {16'd0, half};
    endfunction

    function automatic logic [31:0] convert_word(f2h_pkg::op_t o, logic [31:0] v);
        return (o == f2h_pkg::OP_H2S) ? widen_half(v[15:0]) : narrow_single(v);
    endfunction

    // Random operand shaped so that most single operands land near the interesting
    // boundaries: exponents around the half range, and rounding ties.
    function automatic logic [31:0] random_operand(f2h_pkg::op_t o);
        logic [31:0] v;
        v = $urandom;
        if (o == f2h_pkg::OP_S2H && $urandom_range(0, 3) != 0)
            v[30:23] = 8'($urandom_range(98, 145));
        if (o == f2h_pkg::OP_S2H && $urandom_range(0, 15) == 0)
            v[12:0] = 13'h1000;
        return v;
    endfunction

    // Sends one request; start stays high across back-to-back requests and
    // drops only on an idle cycle, so no edge sees two assignments to it.
    task automatic send_request(f2h_pkg::op_t o, logic [31:0] v, bit allow_idle);
        while (allow_idle && $urandom_range(0, 99) < 11)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        op       <= o;
        value_in <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_words.push_back(convert_word(o, v));
    endtask

    // Result checker: done is sampled at the edge, which is when it is taken.
    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && done)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected result got %08h", $realtime, value_out);
                mismatches++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (value_out !== want)
                begin
                    $display("%0t: value_out expected %08h actual %08h",
                             $realtime, want, value_out);
                    mismatches++;
                end
            end
        end
    end

    // Timeout watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        stim_row_t    rows[$];
        f2h_pkg::op_t o;
        logic [31:0]  v;
        rst_n      = 1'b0;
        start      = 1'b0;
        op         = f2h_pkg::OP_H2S;
        value_in   = 32'd0;
        mismatches = 0;
        cycles     = 0;

        // Directed rows: zeros, subnormals, specials, clamp, rounding ties.
        rows.push_back('{f2h_pkg::OP_H2S, 32'hffff_0000, 1'b1, 32'h0000_0000}); // upper bits ignored
        rows.push_back('{f2h_pkg::OP_H2S, 32'h0000_8000, 1'b1, 32'h0000_0000}); // negative zero
        rows.push_back('{f2h_pkg::OP_H2S, 32'h0000_0001, 1'b1, 32'h3380_0000}); // smallest subnormal
        rows.push_back('{f2h_pkg::OP_H2S, 32'h0000_83ff, 1'b0, 32'h0});        // largest subnormal
        rows.push_back('{f2h_pkg::OP_H2S, 32'h0000_7c00, 1'b1, 32'h7f80_0000}); // infinity
        rows.push_back('{f2h_pkg::OP_H2S, 32'h0000_fe01, 1'b0, 32'h0});        // NaN keeps payload
        rows.push_back('{f2h_pkg::OP_H2S, 32'h0000_7bff, 1'b1, 32'h477f_e000}); // max half
        rows.push_back('{f2h_pkg::OP_H2S, 32'h0000_3c00, 1'b1, 32'h3f80_0000}); // one
        rows.push_back('{f2h_pkg::OP_S2H, 32'h7fc0_0000, 1'b1, 32'h0000_7c01}); // NaN
        rows.push_back('{f2h_pkg::OP_S2H, 32'hff80_0001, 1'b1, 32'h0000_fc01}); // negative NaN
        rows.push_back('{f2h_pkg::OP_S2H, 32'h7f80_0000, 1'b1, 32'h0000_7bff}); // inf saturates
        rows.push_back('{f2h_pkg::OP_S2H, 32'hff80_0000, 1'b1, 32'h0000_fbff}); // negative inf
        rows.push_back('{f2h_pkg::OP_S2H, 32'h477f_e000, 1'b1, 32'h0000_7bff}); // exactly 65504
        rows.push_back('{f2h_pkg::OP_S2H, 32'h477f_dfff, 1'b0, 32'h0});        // just below clamp
        rows.push_back('{f2h_pkg::OP_S2H, 32'h8000_0000, 1'b1, 32'h0000_0000}); // negative zero
        rows.push_back('{f2h_pkg::OP_S2H, 32'h0000_0001, 1'b1, 32'h0000_0000}); // single subnormal
        rows.push_back('{f2h_pkg::OP_S2H, 32'hb2ff_ffff, 1'b1, 32'h0000_0000}); // below 2^-25
        rows.push_back('{f2h_pkg::OP_S2H, 32'h3300_0000, 1'b1, 32'h0000_0001}); // 2^-25 rounds up
        rows.push_back('{f2h_pkg::OP_S2H, 32'h387f_f000, 1'b1, 32'h0000_0400}); // sub to normal
        rows.push_back('{f2h_pkg::OP_S2H, 32'h3f80_1000, 1'b0, 32'h0});        // tie away
        rows.push_back('{f2h_pkg::OP_S2H, 32'h3fff_f000, 1'b1, 32'h0000_4000}); // mantissa carry
        rows.push_back('{f2h_pkg::OP_S2H, 32'hc000_0000, 1'b1, 32'h0000_c000}); // minus two
        rows.push_back('{f2h_pkg::OP_S2H, 32'h5555_5555, 1'b0, 32'h0});
        rows.push_back('{f2h_pkg::OP_H2S, 32'haaaa_aaaa, 1'b0, 32'h0});

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].has_exp && convert_word(rows[i].op, rows[i].value) !== rows[i].exp_word)
            begin
                $display("%0t: table row %0d expected %08h actual %08h", $realtime, i,
                         rows[i].exp_word, convert_word(rows[i].op, rows[i].value));
                mismatches++;
            end
            send_request(rows[i].op, rows[i].value, 1'b0);
        end

        // Random part; the first few hundred requests run without idle cycles.
        for (int n = 0; n < NumRandom; n++)
        begin
            o = f2h_pkg::op_t'($urandom_range(0, 1));
            v = random_operand(o);
            send_request(o, v, n >= 300);
        end
        start <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (TailCycles)
            @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
